// ===== hdl/kmsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmsf_pkg: shared constants for the keypad matrix scanner with code queue
// opcodes, register indexes, key frame patterns and queue defaults
// ----------------------------------------------------------------------------
package kmsf_pkg;

  // default queue depth
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // request opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_SERIAL = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;   // unused, changes nothing

  // configuration register indexes
  localparam logic [2:0] REG_UP     = 3'd0;
  localparam logic [2:0] REG_DOWN   = 3'd1;
  localparam logic [2:0] REG_ESCAPE = 3'd2;
  localparam logic [2:0] REG_ENTER  = 3'd3;
  localparam logic [2:0] REG_RUN    = 3'd4;
  localparam logic [2:0] REG_STOP   = 3'd5;

  // register reset values
  localparam logic [7:0] RST_UP     = 8'd128;
  localparam logic [7:0] RST_DOWN   = 8'd129;
  localparam logic [7:0] RST_ESCAPE = 8'd27;
  localparam logic [7:0] RST_ENTER  = 8'd13;
  localparam logic [7:0] RST_RUN    = 8'd130;
  localparam logic [7:0] RST_STOP   = 8'd131;

  // single-key frame patterns
  localparam logic [15:0] FRM_UP     = 16'h0008;
  localparam logic [15:0] FRM_DOWN   = 16'h0004;
  localparam logic [15:0] FRM_ESCAPE = 16'h0002;
  localparam logic [15:0] FRM_ENTER  = 16'h0001;
  localparam logic [15:0] FRM_RUN    = 16'h0800;
  localparam logic [15:0] FRM_STOP   = 16'h0080;
  localparam logic [15:0] FRM_D0     = 16'h1000;
  localparam logic [15:0] FRM_D1     = 16'h8000;
  localparam logic [15:0] FRM_D2     = 16'h0400;
  localparam logic [15:0] FRM_D3     = 16'h0040;
  localparam logic [15:0] FRM_D4     = 16'h4000;
  localparam logic [15:0] FRM_D5     = 16'h0200;
  localparam logic [15:0] FRM_D6     = 16'h0020;
  localparam logic [15:0] FRM_D7     = 16'h2000;
  localparam logic [15:0] FRM_D8     = 16'h0100;
  localparam logic [15:0] FRM_D9     = 16'h0010;

  // ascii digit codes
  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_1 = 8'h31;
  localparam logic [7:0] ASCII_2 = 8'h32;
  localparam logic [7:0] ASCII_3 = 8'h33;
  localparam logic [7:0] ASCII_4 = 8'h34;
  localparam logic [7:0] ASCII_5 = 8'h35;
  localparam logic [7:0] ASCII_6 = 8'h36;
  localparam logic [7:0] ASCII_7 = 8'h37;
  localparam logic [7:0] ASCII_8 = 8'h38;
  localparam logic [7:0] ASCII_9 = 8'h39;

  // result fields
  typedef struct packed {
    logic       stop_event;
    logic       run_event;
    logic       keypress_event;
    logic [4:0] queue_count;
    logic [7:0] key_code;
    logic       key_valid;
    logic       dropped;
    logic       pushed;
    logic [3:0] column_drive;
  } result_t;

endpackage : kmsf_pkg
`default_nettype wire

// ===== hdl/keypad_matrix_scanner_fifo_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_matrix_scanner_fifo_unit: 4x4 key matrix scanner with code queue
// scans columns one-hot, decodes single-key presses and queues byte codes
// ----------------------------------------------------------------------------
// each accepted request's result is written into the output register on the edge that accepts it
// throughput: one request per cycle; a new request is taken while the result
//   register is empty or being drained in the same cycle
// reset (rst_n low, synchronous): scan state, pointers, fill count and the
//   key code registers return to their defaults; queue storage is not cleared
//   and needs no clearing pass, the fill count guards every read
module keypad_matrix_scanner_fifo_unit #(
  parameter int unsigned QUEUE_DEPTH = kmsf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // row_bits[3:0], serial_byte[11:4], zero pad
  input  wire  [1:0]  in_tuser,   // opcode[1:0]
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // column_drive[3:0], pushed[4], dropped[5],
                                  // key_valid[6], key_code[14:7],
                                  // queue_count[19:15], keypress_event[20],
                                  // run_event[21], stop_event[22], zero pad
  // configuration write port
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [7:0]  cfg_wdata
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // key code registers
  logic [7:0] code_up_r, code_down_r, code_escape_r;
  logic [7:0] code_enter_r, code_run_r, code_stop_r;

  // scan and queue state
  logic [1:0]       col_r, col_nxt;
  logic [15:0]      part_r, part_nxt;
  logic [15:0]      prev_r, prev_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       head_r;   // registered read of the oldest entry

  logic [7:0] mem [QUEUE_DEPTH];

  logic             out_valid_r;
  kmsf_pkg::result_t res_r, res_nxt;

  // request fields
  logic [1:0]  opcode;
  logic [3:0]  row_bits;
  logic [7:0]  serial_byte;
  logic        accept;

  // decode and push control
  logic [15:0] frame;
  logic        key_hit;
  logic [7:0]  key_byte;
  logic        want_push;
  logic [7:0]  push_byte;
  logic        do_push;
  logic        do_pop;
  logic        full;
  logic [CNT_W+4:0] cnt_ext;
  logic [PTR_W-1:0] head_addr;

  assign opcode      = in_tuser;
  assign row_bits    = in_tdata[3:0];
  assign serial_byte = in_tdata[11:4];

  // output register is the skid: take a request whenever it frees up
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  assign frame = {part_r[11:0], row_bits};
  assign full  = (cnt_r == CNT_FULL);

  // read pointer as it stands after this edge
  assign head_addr = accept ? rd_ptr_nxt : rd_ptr_r;

  // single-key frame lookup
  always_comb begin
    key_hit  = 1'b1;
    key_byte = 8'd0;
    case (frame)
      kmsf_pkg::FRM_UP:     key_byte = code_up_r;
      kmsf_pkg::FRM_DOWN:   key_byte = code_down_r;
      kmsf_pkg::FRM_ESCAPE: key_byte = code_escape_r;
      kmsf_pkg::FRM_ENTER:  key_byte = code_enter_r;
      kmsf_pkg::FRM_RUN:    key_byte = code_run_r;
      kmsf_pkg::FRM_STOP:   key_byte = code_stop_r;
      kmsf_pkg::FRM_D0:     key_byte = kmsf_pkg::ASCII_0;
      kmsf_pkg::FRM_D1:     key_byte = kmsf_pkg::ASCII_1;
      kmsf_pkg::FRM_D2:     key_byte = kmsf_pkg::ASCII_2;
      kmsf_pkg::FRM_D3:     key_byte = kmsf_pkg::ASCII_3;
      kmsf_pkg::FRM_D4:     key_byte = kmsf_pkg::ASCII_4;
      kmsf_pkg::FRM_D5:     key_byte = kmsf_pkg::ASCII_5;
      kmsf_pkg::FRM_D6:     key_byte = kmsf_pkg::ASCII_6;
      kmsf_pkg::FRM_D7:     key_byte = kmsf_pkg::ASCII_7;
      kmsf_pkg::FRM_D8:     key_byte = kmsf_pkg::ASCII_8;
      kmsf_pkg::FRM_D9:     key_byte = kmsf_pkg::ASCII_9;
      default:              key_hit  = 1'b0;
    endcase
  end

  // per-request next state and result
  always_comb begin
    col_nxt    = col_r;
    part_nxt   = part_r;
    prev_nxt   = prev_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    want_push  = 1'b0;
    push_byte  = serial_byte;
    do_pop     = 1'b0;
    res_nxt    = '0;

    unique case (opcode)
      kmsf_pkg::OP_SAMPLE: begin
        if (col_r == 2'd3) begin
          // frame complete: only a press from all-released counts
          if (prev_r == 16'd0 && key_hit) begin
            want_push              = 1'b1;
            push_byte              = key_byte;
            res_nxt.keypress_event = 1'b1;
            res_nxt.run_event      = (frame == kmsf_pkg::FRM_RUN);
            res_nxt.stop_event     = (frame == kmsf_pkg::FRM_STOP);
          end
          prev_nxt = frame;
          part_nxt = 16'd0;
          col_nxt  = 2'd0;
        end else begin
          part_nxt = frame;
          col_nxt  = col_r + 2'd1;
        end
      end
      kmsf_pkg::OP_SERIAL: begin
        want_push = (serial_byte != 8'd0);
      end
      kmsf_pkg::OP_POP: begin
        if (cnt_r != '0) begin
          do_pop            = 1'b1;
          res_nxt.key_valid = 1'b1;
          res_nxt.key_code  = head_r;
        end
      end
      default: ;  // unused opcode changes nothing
    endcase

    do_push = want_push && !full;
    res_nxt.pushed  = do_push;
    res_nxt.dropped = want_push && full;

    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      cnt_nxt    = cnt_r + CNT_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      cnt_nxt    = cnt_r - CNT_W'(1);
    end

    res_nxt.column_drive = 4'd1 << col_nxt;
    cnt_ext              = {5'd0, cnt_nxt};
    res_nxt.queue_count  = cnt_ext[4:0];
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept && do_push) begin
      mem[wr_ptr_r] <= push_byte;
    end
  end

  // head read, bypassed when a push lands on the entry about to be read
  always_ff @(posedge clk) begin
    if (accept && do_push && wr_ptr_r == head_addr) begin
      head_r <= push_byte;
    end else begin
      head_r <= mem[head_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 2'd0;
      part_r      <= 16'd0;
      prev_r      <= 16'd0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r    <= col_nxt;
        part_r   <= part_nxt;
        prev_r   <= prev_nxt;
        rd_ptr_r <= rd_ptr_nxt;
        wr_ptr_r <= wr_ptr_nxt;
        cnt_r    <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  // key code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_up_r     <= kmsf_pkg::RST_UP;
      code_down_r   <= kmsf_pkg::RST_DOWN;
      code_escape_r <= kmsf_pkg::RST_ESCAPE;
      code_enter_r  <= kmsf_pkg::RST_ENTER;
      code_run_r    <= kmsf_pkg::RST_RUN;
      code_stop_r   <= kmsf_pkg::RST_STOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmsf_pkg::REG_UP:     code_up_r     <= cfg_wdata;
        kmsf_pkg::REG_DOWN:   code_down_r   <= cfg_wdata;
        kmsf_pkg::REG_ESCAPE: code_escape_r <= cfg_wdata;
        kmsf_pkg::REG_ENTER:  code_enter_r  <= cfg_wdata;
        kmsf_pkg::REG_RUN:    code_run_r    <= cfg_wdata;
        kmsf_pkg::REG_STOP:   code_stop_r   <= cfg_wdata;
        default: ;  // writes beyond the register list are ignored
      endcase
    end
  end

endmodule : keypad_matrix_scanner_fifo_unit
`default_nettype wire
